// ===== design/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal block.
// No dependencies.
package vrt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_AXIS,
        ST_DIV,
        ST_MUL,
        ST_STEP,
        ST_DSET,
        ST_OUT
    } state_t;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    localparam int SQRT_ITERS = 16;

endpackage

// ===== design/voxel_ray_traversal.sv =====
// Voxel ray traversal: 3D grid DDA around one shared shift-add/subtract unit.
// Uses vrt_pkg.
// Start beat: the three squares are summed, then the serial square root, then per nonzero axis
// the divider and shift-add multiplier, then the first step gives the query. Answer beat: one
// step gives a query; a final result follows a shift-add distance multiply per axis. One beat at a time.
// Reset (aresetn low, synchronous): idle, no ray in flight, step_limit 64.
module voxel_ray_traversal #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, solid, zero pad
    input  logic [151:0] s_tdata,
    // op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // voxel_x, voxel_y, voxel_z, hit, face, dist_sqr, zero pad
    output logic [103:0] m_tdata,
    // kind
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int DW = 16 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    vrt_pkg::state_t state_reg, state_next;

    logic [15:0] step_limit_reg, step_limit_next;
    logic        active_reg, active_next;
    logic [31:0] org_reg [3];
    logic [31:0] org_next [3];
    logic [15:0] mag_reg [3];
    logic [15:0] mag_next [3];
    logic [2:0]  neg_reg, neg_next, pos_reg, pos_next;
    logic [15:0] vox_reg [3];
    logic [15:0] vox_next [3];
    logic [47:0] side_reg [3];
    logic [47:0] side_next [3];
    logic [47:0] delta_reg [3];
    logic [47:0] delta_next [3];
    logic [1:0]  last_reg, last_next;
    logic [16:0] count_reg, count_next;
    logic [1:0]  ax_reg, ax_next;
    logic [95:0] acc_reg, acc_next;
    logic [95:0] opa_reg, opa_next;
    logic [47:0] opb_reg, opb_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] len_reg, len_next;
    logic [47:0] sum_reg, sum_next;
    logic        dmode_reg, dmode_next;
    logic        hit_reg, hit_next;
    logic        mvalid_reg, mvalid_next;
    logic [103:0] mdata_reg, mdata_next;
    logic        mlast_reg, mlast_next;

    function automatic logic [47:0] shr_sat(input logic [95:0] v);
        logic [95:0] s;
        s = v >> FRAC_BITS;
        return (s[95:48] != '0) ? vrt_pkg::MAX48 : s[47:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= vrt_pkg::ST_IDLE;
            step_limit_reg <= 16'd64;
            active_reg     <= 1'b0;
            mvalid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_limit_reg <= step_limit_next;
            active_reg     <= active_next;
            mvalid_reg     <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        org_reg   <= org_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        pos_reg   <= pos_next;
        vox_reg   <= vox_next;
        side_reg  <= side_next;
        delta_reg <= delta_next;
        last_reg  <= last_next;
        count_reg <= count_next;
        ax_reg    <= ax_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        cnt_reg   <= cnt_next;
        len_reg   <= len_next;
        sum_reg   <= sum_next;
        dmode_reg <= dmode_next;
        hit_reg   <= hit_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign s_tready  = (state_reg == vrt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tlast   = mlast_reg;

    always_comb begin
        logic [31:0] dsq;
        logic [31:0] bitv;
        logic [31:0] t32;
        logic [16:0] rem;
        logic [DW-1:0] quo;
        logic [FRAC_BITS:0] fr;
        logic [47:0] tsum;
        logic [48:0] s49;
        logic signed [47:0] diff;
        logic [1:0]  a;
        logic [15:0] d16;

        state_next      = state_reg;
        step_limit_next = step_limit_reg;
        active_next     = active_reg;
        org_next        = org_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        vox_next        = vox_reg;
        side_next       = side_reg;
        delta_next      = delta_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        ax_next         = ax_reg;
        acc_next        = acc_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        sum_next        = sum_reg;
        dmode_next      = dmode_reg;
        hit_next        = hit_reg;
        mvalid_next     = mvalid_reg;
        mdata_next      = mdata_reg;
        mlast_next      = mlast_reg;
        dsq  = '0;
        bitv = '0;
        t32  = '0;
        rem  = '0;
        quo  = '0;
        fr   = '0;
        tsum = '0;
        s49  = '0;
        diff = '0;
        a    = 2'd0;
        d16  = '0;

        if (cfg_valid) begin
            step_limit_next = cfg_data;
        end

        unique case (state_reg)
            vrt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == vrt_pkg::OP_START) begin
                        for (int i = 0; i < 3; i++) begin
                            org_next[i] = s_tdata[32*i +: 32];
                            d16 = s_tdata[96 + 16*i +: 16];
                            mag_next[i] = d16[15] ? 16'(-d16) : d16;
                            neg_next[i] = d16[15];
                            pos_next[i] = !d16[15] && (d16 != '0);
                            vox_next[i] = 16'($signed(s_tdata[32*i +: 32]) >>> FRAC_BITS);
                        end
                        count_next  = '0;
                        active_next = 1'b1;
                        sum_next    = '0;
                        ax_next     = 2'd0;
                        state_next  = vrt_pkg::ST_SQ;
                    end else if (active_reg) begin
                        if (s_tdata[144] || (count_reg > {1'b0, step_limit_reg})) begin
                            hit_next    = s_tdata[144];
                            active_next = 1'b0;
                            sum_next    = '0;
                            ax_next     = 2'd0;
                            state_next  = vrt_pkg::ST_DSET;
                        end else begin
                            count_next = count_reg + 17'd1;
                            state_next = vrt_pkg::ST_STEP;
                        end
                    end
                end
            end
            vrt_pkg::ST_SQ: begin
                dsq      = 32'(mag_reg[ax_reg]) * 32'(mag_reg[ax_reg]);
                sum_next = sum_reg + 48'(dsq);
                if (ax_reg == 2'd2) begin
                    acc_next   = 96'(sum_next);
                    opa_next   = '0;
                    cnt_next   = CW'(vrt_pkg::SQRT_ITERS);
                    state_next = vrt_pkg::ST_SQRT;
                end else begin
                    ax_next = ax_reg + 2'd1;
                end
            end
            vrt_pkg::ST_SQRT: begin
                bitv = 32'd1 << {cnt_reg - CW'(1), 1'b0};
                t32  = opa_reg[31:0] + bitv;
                if (acc_reg[31:0] >= t32) begin
                    acc_next = 96'(acc_reg[31:0] - t32);
                    opa_next = 96'((opa_reg[31:0] >> 1) + bitv);
                end else begin
                    opa_next = 96'(opa_reg[31:0] >> 1);
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    len_next   = opa_next[15:0];
                    ax_next    = 2'd0;
                    state_next = vrt_pkg::ST_AXIS;
                end
            end
            vrt_pkg::ST_AXIS: begin
                if (mag_reg[ax_reg] == '0) begin
                    delta_next[ax_reg] = vrt_pkg::MAX48;
                    side_next[ax_reg]  = vrt_pkg::MAX48;
                    if (ax_reg == 2'd2) begin
                        state_next = vrt_pkg::ST_STEP;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else begin
                    acc_next   = 96'({len_reg, {FRAC_BITS{1'b0}}});
                    opa_next   = '0;
                    cnt_next   = CW'(DW);
                    state_next = vrt_pkg::ST_DIV;
                end
            end
            vrt_pkg::ST_DIV: begin
                rem = {opa_reg[15:0], acc_reg[DW-1]};
                quo = {acc_reg[DW-2:0], 1'b0};
                if (rem >= {1'b0, mag_reg[ax_reg]}) begin
                    rem    = rem - {1'b0, mag_reg[ax_reg]};
                    quo[0] = 1'b1;
                end
                opa_next = 96'(rem);
                acc_next = 96'(quo);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    delta_next[ax_reg] = 48'(quo);
                    fr = neg_reg[ax_reg] ? {1'b0, org_reg[ax_reg][FRAC_BITS-1:0]}
                                         : ({1'b1, {FRAC_BITS{1'b0}}}
                                            - {1'b0, org_reg[ax_reg][FRAC_BITS-1:0]});
                    opa_next   = 96'(quo);
                    opb_next   = 48'(fr);
                    acc_next   = '0;
                    dmode_next = 1'b0;
                    state_next = vrt_pkg::ST_MUL;
                end
            end
            vrt_pkg::ST_MUL: begin
                if (opb_reg == '0) begin
                    if (!dmode_reg) begin
                        side_next[ax_reg] = shr_sat(acc_reg);
                        if (ax_reg == 2'd2) begin
                            state_next = vrt_pkg::ST_STEP;
                        end else begin
                            ax_next    = ax_reg + 2'd1;
                            state_next = vrt_pkg::ST_AXIS;
                        end
                    end else begin
                        tsum     = shr_sat(acc_reg);
                        s49      = {1'b0, sum_reg} + {1'b0, tsum};
                        sum_next = s49[48] ? vrt_pkg::MAX48 : s49[47:0];
                        if (ax_reg == 2'd2) begin
                            mdata_next = {4'd0, sum_next,
                                          3'({last_reg, 1'b0}) + 3'(!pos_reg[last_reg]),
                                          hit_reg, vox_reg[2], vox_reg[1], vox_reg[0]};
                            mlast_next  = vrt_pkg::KIND_FINAL;
                            mvalid_next = 1'b1;
                            state_next  = vrt_pkg::ST_OUT;
                        end else begin
                            ax_next    = ax_reg + 2'd1;
                            state_next = vrt_pkg::ST_DSET;
                        end
                    end
                end else begin
                    if (opb_reg[0]) begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
            end
            vrt_pkg::ST_DSET: begin
                diff = ($signed(48'($signed(vox_reg[ax_reg]))) <<< FRAC_BITS)
                       - $signed(48'($signed(org_reg[ax_reg])));
                opb_next   = diff[47] ? 48'(-diff) : 48'(diff);
                opa_next   = 96'(opb_next);
                acc_next   = '0;
                dmode_next = 1'b1;
                state_next = vrt_pkg::ST_MUL;
            end
            vrt_pkg::ST_STEP: begin
                if (side_reg[0] < side_reg[1] && side_reg[0] < side_reg[2]) begin
                    a = 2'd0;
                end else if (side_reg[1] < side_reg[2]) begin
                    a = 2'd1;
                end else begin
                    a = 2'd2;
                end
                s49 = {1'b0, side_reg[a]} + {1'b0, delta_reg[a]};
                side_next[a] = s49[48] ? vrt_pkg::MAX48 : s49[47:0];
                vox_next[a]  = neg_reg[a] ? vox_reg[a] - 16'd1 : vox_reg[a] + 16'd1;
                last_next    = a;
                mdata_next   = {56'd0, vox_next[2], vox_next[1], vox_next[0]};
                mlast_next   = vrt_pkg::KIND_QUERY;
                mvalid_next  = 1'b1;
                state_next   = vrt_pkg::ST_OUT;
            end
            vrt_pkg::ST_OUT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = vrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/vrt_checker.sv =====
// Port-level checks for voxel_ray_traversal, bound to the top level.
// Depends on the top-level port list only.
module vrt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result waits");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("ready straight after a start beat");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("second result without a new input beat");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
